@@ rtl/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg
// Types, codes and constants shared by the sorted breakpoint table.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam logic [31:0] BrkBase = 32'hF200_0000;
  localparam logic [15:0] UidBase = 16'h2000;

  typedef enum logic [1:0] {
    ACT_ADD        = 2'd0,
    ACT_REMOVE     = 2'd1,
    ACT_REMOVE_ALL = 2'd2,
    ACT_NOP        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_EXISTS     = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FAULT      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] bp_address;
    logic        persist_flag;
    logic [31:0] old_instruction;
    logic        access_ok;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        write_valid;
    logic [63:0] write_address;
    logic [31:0] write_data;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input word, reset index
    logic step;        // advance index
    logic ins_shift;   // copy entry idx-1 to idx, step index down
    logic ins_write;   // write new entry at idx
    logic rem_shift;   // copy entry idx+1 to idx, step index up
    logic rem_done;    // decrement count
    logic clear;       // empty table and counter
    logic set_end;     // set index to count (insert shift start)
    logic set_pos;     // set index to search position
    logic rst_idx;     // set index to zero
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_at_count;  // idx >= count
    logic entry_below;   // entry[idx].addr < addr
    logic entry_equal;
    logic idx_at_pos;    // idx == pos
    logic last_shift;    // idx + 1 >= count
    logic full;
    logic need_restore;  // entry[idx] applied and not kept
  } stat_t;

endpackage

@@ rtl/sbt_datapath.sv @@
// ----------------------------------------------------------------------------
// sbt_datapath
// Entry registers, index, counters and the compare used by the search.
// ----------------------------------------------------------------------------
module sbt_datapath #(
  parameter int Depth = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbt_pkg::in_word_t in_i,
  input  sbt_pkg::cmd_t     cmd_i,
  output sbt_pkg::stat_t    stat_o,
  output sbt_pkg::in_word_t req_o,
  output logic [63:0]       cur_addr_o,
  output logic [31:0]       cur_word_o,
  output logic [15:0]       new_uid_o
);
  localparam int IdxW  = $clog2(Depth + 1);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [63:0] addr_q   [Depth];
  logic [31:0] word_q   [Depth];
  logic [15:0] uid_q    [Depth];
  logic        pers_q   [Depth];
  logic        appl_q   [Depth];

  sbt_pkg::in_word_t req_q;
  logic [IdxW-1:0]   idx_q, pos_q, cnt_q;
  logic [15:0]       ctr_q;
  logic [IdxW-1:0]   rd;
  logic [IdxW-1:0]   idx_m1, idx_p1;
  logic [AddrW-1:0]  ra, ra_m1, ra_p1;

  assign idx_m1 = idx_q - IdxW'(1);
  assign idx_p1 = idx_q + IdxW'(1);

  // read point follows the index, clamped into the table
  always_comb begin
    rd = (idx_q >= IdxW'(Depth)) ? IdxW'(Depth - 1) : idx_q;
  end

  assign ra    = AddrW'(rd);
  assign ra_m1 = ra - AddrW'(1);
  assign ra_p1 = AddrW'(idx_p1);

  assign cur_addr_o = addr_q[ra];
  assign cur_word_o = word_q[ra];
  assign new_uid_o  = sbt_pkg::UidBase + ctr_q;
  assign req_o      = req_q;

  always_comb begin
    stat_o.idx_at_count = (idx_q >= cnt_q);
    stat_o.entry_below  = (addr_q[ra] < req_q.bp_address);
    stat_o.entry_equal  = (addr_q[ra] == req_q.bp_address);
    stat_o.idx_at_pos   = (idx_q == pos_q);
    stat_o.last_shift   = (idx_p1 >= cnt_q);
    stat_o.full         = (cnt_q >= IdxW'(Depth));
    stat_o.need_restore = appl_q[ra] && !(req_q.persist_flag && pers_q[ra]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      ctr_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.rst_idx) idx_q <= '0;
      else if (cmd_i.step || cmd_i.rem_shift) idx_q <= idx_p1;
      else if (cmd_i.ins_shift) idx_q <= idx_m1;
      else if (cmd_i.set_end) begin
        idx_q <= cnt_q;
        pos_q <= idx_q;
      end else if (cmd_i.set_pos) idx_q <= pos_q;
      if (cmd_i.ins_write) begin
        cnt_q <= cnt_q + IdxW'(1);
        ctr_q <= ctr_q + 16'd1;
      end
      if (cmd_i.rem_done) cnt_q <= cnt_q - IdxW'(1);
      if (cmd_i.clear) begin
        cnt_q <= '0;
        ctr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_i;
    if (cmd_i.ins_shift) begin
      addr_q[ra] <= addr_q[ra_m1];
      word_q[ra] <= word_q[ra_m1];
      uid_q[ra]  <= uid_q[ra_m1];
      pers_q[ra] <= pers_q[ra_m1];
      appl_q[ra] <= appl_q[ra_m1];
    end
    if (cmd_i.rem_shift && idx_p1 < IdxW'(Depth)) begin
      addr_q[ra] <= addr_q[ra_p1];
      word_q[ra] <= word_q[ra_p1];
      uid_q[ra]  <= uid_q[ra_p1];
      pers_q[ra] <= pers_q[ra_p1];
      appl_q[ra] <= appl_q[ra_p1];
    end
    if (cmd_i.ins_write) begin
      addr_q[ra] <= req_q.bp_address;
      word_q[ra] <= req_q.old_instruction;
      uid_q[ra]  <= new_uid_o;
      pers_q[ra] <= req_q.persist_flag;
      appl_q[ra] <= req_q.access_ok;
    end
  end

endmodule

@@ rtl/sbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbt_ctrl
// Sequencer for add, remove and remove-all; drives the result word.
// ----------------------------------------------------------------------------
module sbt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         action_i,
  input  logic [1:0]         bp_low_i,
  output logic               busy_o,
  input  sbt_pkg::stat_t     stat_i,
  input  sbt_pkg::in_word_t  req_i,
  input  logic [63:0]        cur_addr_i,
  input  logic [31:0]        cur_word_i,
  input  logic [15:0]        new_uid_i,
  output sbt_pkg::cmd_t      cmd_o,
  output logic               res_valid_o,
  output sbt_pkg::out_word_t res_o
);
  sbt_pkg::state_e state_q, state_d;
  logic fail_q, fail_d;
  logic        rv_d;
  sbt_pkg::out_word_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbt_pkg::S_IDLE;
      fail_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      fail_q      <= fail_d;
      res_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  assign busy_o = (state_q != sbt_pkg::S_IDLE);

  function automatic sbt_pkg::out_word_t fin(logic [2:0] st);
    sbt_pkg::out_word_t w;
    w = '0;
    w.status = st;
    w.last   = 1'b1;
    return w;
  endfunction

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    cmd_o   = '0;
    rv_d    = 1'b0;
    res_d   = '0;
    unique case (state_q)
      sbt_pkg::S_IDLE: begin
        fail_d = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if ((action_i == sbt_pkg::ACT_ADD || action_i == sbt_pkg::ACT_REMOVE) &&
              bp_low_i != 2'b00) begin
            rv_d  = 1'b1;
            res_d = fin(sbt_pkg::ST_MISALIGNED);
          end else if (action_i == sbt_pkg::ACT_REMOVE_ALL) state_d = sbt_pkg::S_SCAN;
          else if (action_i == sbt_pkg::ACT_NOP) begin
            rv_d  = 1'b1;
            res_d = fin(sbt_pkg::ST_OK);
          end else state_d = sbt_pkg::S_SEARCH;
        end
      end
      sbt_pkg::S_SEARCH: begin
        // walk up to the first entry not below the address
        if (!stat_i.idx_at_count && stat_i.entry_below) cmd_o.step = 1'b1;
        else state_d = sbt_pkg::S_DECIDE;
      end
      sbt_pkg::S_DECIDE: begin
        if (req_i.action == sbt_pkg::ACT_ADD) begin
          if (!stat_i.idx_at_count && stat_i.entry_equal) begin
            rv_d = 1'b1; res_d = fin(sbt_pkg::ST_EXISTS); state_d = sbt_pkg::S_IDLE;
          end else if (stat_i.full) begin
            rv_d = 1'b1; res_d = fin(sbt_pkg::ST_FULL); state_d = sbt_pkg::S_IDLE;
          end else begin
            cmd_o.set_end = 1'b1;
            state_d = sbt_pkg::S_SHIFT;
          end
        end else begin
          if (stat_i.idx_at_count || !stat_i.entry_equal) begin
            rv_d = 1'b1; res_d = fin(sbt_pkg::ST_NOT_FOUND); state_d = sbt_pkg::S_IDLE;
          end else begin
            if (stat_i.need_restore) begin
              if (req_i.access_ok) begin
                rv_d = 1'b1;
                res_d.write_valid   = 1'b1;
                res_d.write_address = cur_addr_i;
                res_d.write_data    = cur_word_i;
              end else fail_d = 1'b1;
            end
            state_d = sbt_pkg::S_SHIFT;
          end
        end
      end
      sbt_pkg::S_SHIFT: begin
        if (req_i.action == sbt_pkg::ACT_ADD) begin
          if (!stat_i.idx_at_pos) cmd_o.ins_shift = 1'b1;
          else begin
            cmd_o.ins_write = 1'b1;
            rv_d = 1'b1;
            if (req_i.access_ok) begin
              res_d.write_valid   = 1'b1;
              res_d.write_address = req_i.bp_address;
              res_d.write_data    = sbt_pkg::BrkBase | {16'h0, new_uid_i};
              state_d = sbt_pkg::S_FINISH;
            end else begin
              res_d = fin(sbt_pkg::ST_FAULT);
              state_d = sbt_pkg::S_IDLE;
            end
          end
        end else begin
          if (!stat_i.last_shift) cmd_o.rem_shift = 1'b1;
          else begin
            cmd_o.rem_done = 1'b1;
            state_d = sbt_pkg::S_FINISH;
          end
        end
      end
      sbt_pkg::S_SCAN: begin
        // restore in ascending order, stop at the first failure
        if (stat_i.idx_at_count || fail_q) begin
          cmd_o.clear = 1'b1;
          state_d = sbt_pkg::S_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          if (stat_i.need_restore) begin
            if (req_i.access_ok) begin
              rv_d = 1'b1;
              res_d.write_valid   = 1'b1;
              res_d.write_address = cur_addr_i;
              res_d.write_data    = cur_word_i;
            end else fail_d = 1'b1;
          end
        end
      end
      sbt_pkg::S_FINISH: begin
        rv_d  = 1'b1;
        res_d = fin(fail_q ? sbt_pkg::ST_FAULT : sbt_pkg::ST_OK);
        state_d = sbt_pkg::S_IDLE;
      end
      default: state_d = sbt_pkg::S_IDLE;
    endcase
  end

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy_o || $past(state_q) == sbt_pkg::S_IDLE)
    else $error("final word while busy");
  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.write_valid) |-> !res_o.last && busy_o)
    else $error("write word marked last or after end");
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> cmd_o.load)
    else $error("accepted word not captured");

endmodule

@@ rtl/sorted_breakpoint_table.sv @@
// ----------------------------------------------------------------------------
// sorted_breakpoint_table
// Sorted breakpoint table: add, remove and remove-all with patch writes.
// Misaligned or unused actions are answered straight from idle; add and remove
// first search, then are rejected or shift entries; remove-all scans the table.
// Throughput: one word at a time, busy until the final result; the entry walk
// and shift through one index register set it.
// Reset clears count, uid counter and controller; results cannot stall.
// ----------------------------------------------------------------------------
module sorted_breakpoint_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sbt_pkg::in_word_t  in_word_i,
  output logic               res_valid_o,
  output sbt_pkg::out_word_t res_word_o
);
  sbt_pkg::cmd_t     cmd;
  sbt_pkg::stat_t    stat;
  sbt_pkg::in_word_t req;
  logic [63:0]       cur_addr;
  logic [31:0]       cur_word;
  logic [15:0]       new_uid;

  sbt_datapath #(.Depth(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .in_i(in_word_i), .cmd_i(cmd), .stat_o(stat),
    .req_o(req), .cur_addr_o(cur_addr), .cur_word_o(cur_word), .new_uid_o(new_uid)
  );

  sbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .action_i(in_word_i.action),
    .bp_low_i(in_word_i.bp_address[1:0]), .busy_o(busy), .stat_i(stat),
    .req_i(req), .cur_addr_i(cur_addr), .cur_word_i(cur_word), .new_uid_i(new_uid),
    .cmd_o(cmd), .res_valid_o(res_valid_o), .res_o(res_word_o)
  );

endmodule
